@@ src/ile_pkg.sv @@
package ile_pkg;

    localparam int CAPACITY_DEFAULT      = 256;
    localparam int ELEMENT_WIDTH_DEFAULT = 32;

    // request operation codes
    localparam logic [3:0] MODE_APPEND = 4'd0;
    localparam logic [3:0] MODE_INSERT = 4'd1;
    localparam logic [3:0] MODE_SET    = 4'd2;
    localparam logic [3:0] MODE_GET    = 4'd3;
    localparam logic [3:0] MODE_ERASE  = 4'd4;
    localparam logic [3:0] MODE_POP    = 4'd5;
    localparam logic [3:0] MODE_EXIST  = 4'd6;
    localparam logic [3:0] MODE_REMOVE = 4'd7;
    localparam logic [3:0] MODE_CLEAR  = 4'd8;

    // result status codes
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_RANGE    = 3'd1;
    localparam logic [2:0] STATUS_FULL     = 3'd2;
    localparam logic [2:0] STATUS_EMPTY    = 3'd3;
    localparam logic [2:0] STATUS_NOTFOUND = 3'd4;

    localparam int IN_DATA_WIDTH   = 40;
    localparam int OUT_DATA_WIDTH  = 48;
    localparam int COUNT_OUT_WIDTH = 9;

endpackage

@@ src/ile_ram.sv @@
module ile_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/indexed_list_engine.sv @@
// channel  dir  tdata (low bit up)                          tuser (low bit up)
// s_*      in   position[7:0], value_in[39:8]               mode[3:0]
// m_*      out  value_out[31:0], entry_count[40:32], 0 pad  status[2:0], found[3]
//
// One request at a time; s_tready is high only while idle.
// append, set, clear and unknown modes go straight to done; get and pop wait on a read.
// exist scans from index 0 and stops at a hit or at the count; insert moves the
// entries from the tail down to position, erase from position up; remove: scan + shift.
// Shifts and searches walk the dual-port entry memory, one entry per cycle.
// Reset clears all registers, not the memory; done holds while an old output waits.
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEFAULT,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_WIDTH-1:0]  s_tdata,   // position[7:0], value_in[39:8]
    input  logic [3:0]                s_tuser,   // mode[3:0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_WIDTH-1:0] m_tdata,   // value_out[31:0], entry_count[40:32]
    output logic [3:0]                m_tuser    // status[2:0], found[3]
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 8;
    localparam int EW = ELEMENT_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [3:0]      mode_reg, mode_next;
    logic [7:0]      pos_reg, pos_next;
    logic [EW-1:0]   val_reg, val_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pend_addr_reg, pend_addr_next;
    logic            cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]   cmp_addr_reg, cmp_addr_next;
    logic [31:0]     res_value_reg, res_value_next;
    logic [2:0]      res_status_reg, res_status_next;
    logic            res_found_reg, res_found_next;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     out_value_reg, out_value_next;
    logic [2:0]      out_status_reg, out_status_next;
    logic            out_found_reg, out_found_next;
    logic [COUNT_OUT_WIDTH-1:0] out_count_reg, out_count_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;

    logic [3:0]      in_mode;
    logic [7:0]      in_pos;
    logic [31:0]     in_value;
    logic [EW+31:0]  in_val_wide;
    logic [EW-1:0]   in_val;
    logic [EW+31:0]  rd_wide;
    logic [31:0]     rd_value;
    logic [PW-1:0]   in_pos_w;
    logic [PW-1:0]   pos_w;
    logic [PW-1:0]   count_w;
    logic [PW-1:0]   idx_w;
    logic [CW+8:0]   count_out_wide;
    logic            accept;
    logic            full;
    logic            more;
    logic            cmp_hit;

    ile_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_mode     = s_tuser[3:0];
    assign in_pos      = s_tdata[7:0];
    assign in_value    = s_tdata[39:8];
    assign in_val_wide = {{EW{1'b0}}, in_value};
    assign in_val      = in_val_wide[EW-1:0];
    assign rd_wide     = {32'b0, ram_rdata};
    assign rd_value    = rd_wide[31:0];

    assign in_pos_w = {{CW{1'b0}}, in_pos};
    assign pos_w    = {{CW{1'b0}}, pos_reg};
    assign count_w  = {8'b0, count_reg};
    assign idx_w    = {8'b0, idx_reg};
    assign count_out_wide = {9'b0, count_reg};

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign cmp_hit  = cmp_valid_reg && (ram_rdata == val_reg);

    // insert walks down to position, erase and remove walk up to the last entry
    assign more = (mode_reg == MODE_INSERT) ? (idx_w > pos_w)
                                            : ((idx_reg + 1'b1) < count_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_count_reg, out_value_reg};
    assign m_tuser  = {out_found_reg, out_status_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_addr_next   = cmp_addr_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next       = in_mode;
                    pos_next        = in_pos;
                    val_next        = in_val;
                    res_value_next  = '0;
                    res_status_next = STATUS_OK;
                    res_found_next  = 1'b0;
                    pend_next       = 1'b0;
                    cmp_valid_next  = 1'b0;
                    state_next      = ST_DONE;
                    case (in_mode)
                        MODE_APPEND:
                        begin
                            if (full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = in_val;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (in_pos_w > count_w)
                            begin
                                res_status_next = STATUS_RANGE;
                            end
                            else if (full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = ST_SHIFT;
                            end
                        end
                        MODE_SET:
                        begin
                            if (in_pos_w >= count_w)
                            begin
                                res_status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = in_pos_w[AW-1:0];
                                ram_wdata = in_val;
                            end
                        end
                        MODE_GET:
                        begin
                            if (in_pos_w >= count_w)
                            begin
                                res_status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = in_pos_w[AW-1:0];
                                state_next = ST_RDWAIT;
                            end
                        end
                        MODE_ERASE:
                        begin
                            if (in_pos_w >= count_w)
                            begin
                                res_status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                idx_next   = in_pos_w[CW-1:0];
                                state_next = ST_SHIFT;
                            end
                        end
                        MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                ram_re     = 1'b1;
                                ram_raddr  = count_next[AW-1:0];
                                state_next = ST_RDWAIT;
                            end
                        end
                        MODE_EXIST, MODE_REMOVE:
                        begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RDWAIT:
            begin
                res_value_next = rd_value;
                state_next     = ST_DONE;
            end

            ST_SCAN:
            begin
                // read one entry per cycle, compare it in the next cycle
                if (idx_reg < count_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = idx_reg[AW-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_addr_next  = idx_reg[AW-1:0];
                    idx_next       = idx_reg + 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end

                if (cmp_hit)
                begin
                    res_found_next = 1'b1;
                    cmp_valid_next = 1'b0;
                    if (mode_reg == MODE_EXIST)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = {{(CW-AW){1'b0}}, cmp_addr_reg};
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT;
                    end
                end
                else if (!cmp_valid_reg && !(idx_reg < count_reg))
                begin
                    res_status_next = STATUS_NOTFOUND;
                    state_next      = ST_DONE;
                end
            end

            ST_SHIFT:
            begin
                // entry read last cycle lands one place over
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end

                if (more)
                begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                    if (mode_reg == MODE_INSERT)
                    begin
                        ram_raddr = idx_reg[AW-1:0] - 1'b1;
                        idx_next  = idx_reg - 1'b1;
                    end
                    else
                    begin
                        ram_raddr = idx_reg[AW-1:0] + 1'b1;
                        idx_next  = idx_reg + 1'b1;
                    end
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    if (mode_reg == MODE_INSERT)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = pos_w[AW-1:0];
                        ram_wdata  = val_reg;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    out_count_next  = count_out_wide[COUNT_OUT_WIDTH-1:0];
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            mode_reg       <= '0;
            pos_reg        <= '0;
            val_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_addr_reg   <= '0;
            res_value_reg  <= '0;
            res_status_reg <= STATUS_OK;
            res_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= STATUS_OK;
            out_found_reg  <= 1'b0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            val_reg        <= val_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= pend_addr_next;
            cmp_valid_reg  <= cmp_valid_next;
            cmp_addr_reg   <= cmp_addr_next;
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
            out_count_reg  <= out_count_next;
        end
    end

endmodule
